// File: src/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

  // request and result field widths
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 10;
  localparam int TLEN_W   = 13;
  localparam int STATUS_W = 3;
  localparam int OFF_W    = 13;
  localparam int CNT_W    = 11;
  localparam int FREE_W   = 13;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_BITS      = KIND_W + SLOT_W + TLEN_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = STATUS_W + SLOT_W + OFF_W + TLEN_W + 2 * CNT_W + FREE_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT   = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_GET    = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_BAD_SIZE  = 3'd1,
    STS_CORRUPT   = 3'd2,
    STS_NO_SPACE  = 3'd3,
    STS_RANGE     = 3'd4,
    STS_DELETED   = 3'd5,
    STS_CONTENT   = 3'd6
  } status_t;

endpackage

// File: src/spm_slot_ram.sv
`timescale 1ns / 1ps

// slot directory store, one read and one write port, registered read data
module spm_slot_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 27
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/slotted_page_slot_manager.sv
`timescale 1ns / 1ps

// Slot directory manager for one slotted page.
// Requests come in on the s_axis channel (init, insert, update, delete, get with a
// slot index and a tuple length); one result per request leaves on m_axis with
// status, chosen slot, data offset and length, live and deleted counts and free bytes.
// Each request runs through an accept cycle and an evaluate state: the accept cycle
// issues the read of one slot entry (the addressed slot, or the free-list head for an
// insert), and the evaluate state that follows evaluates that entry, writes the updated
// entry back when the request changes it and loads the result register.
// s_axis_tready is high only while no request is in flight, so a read never
// overlaps the write-back of the request before it.
// The result register decouples the sides: a new request is taken while a result
// still waits; if the receiver stalls, the next request holds in its evaluate cycle
// until the result register frees up, with no state change until then.
// Reset clears the counters, sets the data start to the page end and empties the
// free list; the slot memory is not cleared and needs no clearing pass, since only
// entries written since the last init are ever looked at.
// Free space is tracked as its own register that moves in step with data start and
// the slot count, so no multiply by the slot size sits in the datapath.
module slotted_page_slot_manager #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 32,
  parameter int SLOT_BYTES   = 4,
  parameter int MAX_SLOTS    = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // kind[2:0], slot_index[12:3], tuple_length[25:13]
  input  logic [spm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[2:0], result_slot[12:3], data_offset[25:13], data_length[38:26],
  // live_tuples[49:39], dead_slots[60:50], free_bytes[73:61]
  output logic [spm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int CW  = $clog2(MAX_SLOTS + 1);      // counts and free-list links
  localparam int SW  = $clog2(MAX_SLOTS);          // slot memory address
  localparam int PW  = $clog2(PAGE_BYTES + 1);     // byte positions in the page
  localparam int OW  = (PW > CW) ? PW : CW;        // offset field, also holds links
  localparam int LW  = spm_pkg::TLEN_W;
  localparam int EW  = 1 + LW + OW;                // entry: {deleted, length, offset}
  localparam int KW  = ((OW > spm_pkg::SLOT_W) ? OW : spm_pkg::SLOT_W) + 1;
  localparam int NW  = ((PW > LW) ? PW : LW) + 1;
  localparam int MAX_TUPLE = PAGE_BYTES - HEADER_BYTES - SLOT_BYTES;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state;

  // request fields
  logic [spm_pkg::KIND_W-1:0] in_kind;
  logic [spm_pkg::SLOT_W-1:0] in_sidx;
  logic [LW-1:0]              in_len;
  logic                       s_acc;

  // latched request
  logic [spm_pkg::KIND_W-1:0] req_kind;
  logic [spm_pkg::SLOT_W-1:0] req_sidx;
  logic [LW-1:0]              req_len;

  // page counters
  logic [CW-1:0] used, used_next;
  logic [CW-1:0] live, live_next;
  logic [CW-1:0] dead, dead_next;
  logic [PW-1:0] data_start, data_start_next;
  logic [PW-1:0] space, space_next;
  logic [CW-1:0] free_head, free_head_next;

  // slot memory ports
  logic [SW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // evaluated result
  spm_pkg::status_t           sts;
  logic [spm_pkg::SLOT_W-1:0] rslot;
  logic [OW-1:0]              doff;
  logic [LW-1:0]              dlen;

  // entry fields and checks
  logic          rd_del;
  logic [LW-1:0] rd_len;
  logic [OW-1:0] rd_off;
  logic          fire;
  logic          sidx_oor;
  logic          fresh;
  logic          head_oor;
  logic          link_bad;
  logic          len_bad;
  logic [NW-1:0] need;
  logic          short_need;
  logic          short_len;
  logic          dir_full;
  logic          content_bad;
  logic [PW-1:0] ds_minus_len;
  logic [SW-1:0] ins_slot;

  // result register
  logic                         out_valid;
  logic [spm_pkg::OUT_TDATA_W-1:0] out_data;

  assign in_kind = s_axis_tdata[spm_pkg::KIND_W-1:0];
  assign in_sidx = s_axis_tdata[spm_pkg::KIND_W +: spm_pkg::SLOT_W];
  assign in_len  = s_axis_tdata[spm_pkg::KIND_W + spm_pkg::SLOT_W +: LW];

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign fire          = (state == ST_EXEC) && (!out_valid || m_axis_tready);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // insert looks at the free-list head, everything else at the addressed slot
  assign rd_addr = (in_kind == spm_pkg::KIND_INSERT) ? SW'(free_head) : SW'(in_sidx);

  spm_slot_ram #(
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (SW),
    .DATA_W (EW)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (s_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign rd_del = rd_data[EW-1];
  assign rd_len = rd_data[OW +: LW];
  assign rd_off = rd_data[OW-1:0];

  assign sidx_oor = KW'(req_sidx) >= KW'(used);
  assign fresh    = (free_head == CW'(MAX_SLOTS));
  assign head_oor = free_head >= used;
  // successor link must be nil or a slot in use
  assign link_bad = (KW'(rd_off) != KW'(MAX_SLOTS)) && (KW'(rd_off) >= KW'(used));
  assign len_bad  = (req_len == '0) ||
                    ((MAX_TUPLE >= 0) && (32'(req_len) > 32'(MAX_TUPLE)));
  assign need       = NW'(req_len) + (fresh ? NW'(SLOT_BYTES) : NW'(0));
  assign short_need = NW'(space) < need;
  assign short_len  = NW'(space) < NW'(req_len);
  assign dir_full   = 32'(used) >= 32'(MAX_SLOTS);
  assign content_bad = (rd_len == '0) ||
                       ((32'(rd_off) + 32'(rd_len)) > 32'(PAGE_BYTES));
  assign ds_minus_len = data_start - PW'(req_len);
  assign ins_slot     = fresh ? SW'(used) : SW'(free_head);

  always_comb begin
    sts             = spm_pkg::STS_OK;
    rslot           = req_sidx;
    doff            = '0;
    dlen            = '0;
    used_next       = used;
    live_next       = live;
    dead_next       = dead;
    data_start_next = data_start;
    space_next      = space;
    free_head_next  = free_head;
    wr_en           = 1'b0;
    wr_addr         = SW'(req_sidx);
    wr_data         = rd_data;

    unique case (req_kind)
      spm_pkg::KIND_INIT: begin
        used_next       = '0;
        live_next       = '0;
        dead_next       = '0;
        data_start_next = PW'(PAGE_BYTES);
        space_next      = PW'(PAGE_BYTES - HEADER_BYTES);
        free_head_next  = CW'(MAX_SLOTS);
      end
      spm_pkg::KIND_INSERT: begin
        rslot = '0;
        priority if (len_bad) begin
          sts = spm_pkg::STS_BAD_SIZE;
        end else if (!fresh && (head_oor || !rd_del || link_bad)) begin
          sts = spm_pkg::STS_CORRUPT;
        end else if (short_need || (fresh && dir_full)) begin
          sts = spm_pkg::STS_NO_SPACE;
        end else if (!fresh && (dead == '0)) begin
          sts = spm_pkg::STS_CORRUPT;
        end else begin
          // reuse the free-list head, or append a new slot
          if (fresh) begin
            used_next = used + 1'b1;
          end else begin
            free_head_next = CW'(rd_off);
            dead_next      = dead - 1'b1;
          end
          live_next       = live + 1'b1;
          data_start_next = ds_minus_len;
          space_next      = space - PW'(need);
          wr_en           = 1'b1;
          wr_addr         = ins_slot;
          wr_data         = {1'b0, req_len, OW'(ds_minus_len)};
          rslot           = spm_pkg::SLOT_W'(ins_slot);
          doff            = OW'(ds_minus_len);
          dlen            = req_len;
        end
      end
      spm_pkg::KIND_UPDATE: begin
        priority if (sidx_oor) begin
          sts = spm_pkg::STS_RANGE;
        end else if (rd_del) begin
          sts = spm_pkg::STS_DELETED;
        end else if (len_bad) begin
          sts = spm_pkg::STS_BAD_SIZE;
        end else if (req_len <= rd_len) begin
          // shrink in place
          wr_en   = 1'b1;
          wr_data = {1'b0, req_len, rd_off};
          doff    = rd_off;
          dlen    = req_len;
        end else if (short_len) begin
          sts = spm_pkg::STS_NO_SPACE;
        end else begin
          // grow: move data to fresh space below data start
          data_start_next = ds_minus_len;
          space_next      = space - PW'(req_len);
          wr_en           = 1'b1;
          wr_data         = {1'b0, req_len, OW'(ds_minus_len)};
          doff            = OW'(ds_minus_len);
          dlen            = req_len;
        end
      end
      spm_pkg::KIND_DELETE: begin
        priority if (sidx_oor) begin
          sts = spm_pkg::STS_RANGE;
        end else if (rd_del) begin
          sts = spm_pkg::STS_DELETED;
        end else begin
          // push on the free list, link through the offset field
          wr_en          = 1'b1;
          wr_data        = {1'b1, rd_len, OW'(free_head)};
          free_head_next = CW'(req_sidx);
          live_next      = (live != '0) ? live - 1'b1 : live;
          dead_next      = dead + 1'b1;
        end
      end
      spm_pkg::KIND_GET: begin
        priority if (sidx_oor) begin
          sts = spm_pkg::STS_RANGE;
        end else if (rd_del) begin
          sts = spm_pkg::STS_DELETED;
        end else if (content_bad) begin
          sts = spm_pkg::STS_CONTENT;
        end else begin
          doff = rd_off;
          dlen = rd_len;
        end
      end
      default: begin
        // unknown kind: no state change
      end
    endcase

    if (!fire) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      used       <= '0;
      live       <= '0;
      dead       <= '0;
      data_start <= PW'(PAGE_BYTES);
      space      <= PW'(PAGE_BYTES - HEADER_BYTES);
      free_head  <= CW'(MAX_SLOTS);
    end else begin
      // a result loaded in the same cycle takes over the register
      if (m_axis_tvalid && m_axis_tready && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            req_kind <= in_kind;
            req_sidx <= in_sidx;
            req_len  <= in_len;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            used       <= used_next;
            live       <= live_next;
            dead       <= dead_next;
            data_start <= data_start_next;
            space      <= space_next;
            free_head  <= free_head_next;
            out_valid  <= 1'b1;
            out_data   <= spm_pkg::OUT_TDATA_W'({
                            spm_pkg::FREE_W'(space_next),
                            spm_pkg::CNT_W'(dead_next),
                            spm_pkg::CNT_W'(live_next),
                            dlen,
                            spm_pkg::OFF_W'(doff),
                            rslot,
                            sts
                          });
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/spm_checker.sv
`timescale 1ns / 1ps

module spm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [spm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [spm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_axis_tready)
    else $error("request taken during evaluate cycle");

  // result appears in the cycle after the evaluate cycle when the register is free
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_acc ##1 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("request produced no result");

  // status code within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[spm_pkg::STATUS_W-1:0] <= spm_pkg::STS_CONTENT)
    else $error("undefined status code");

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind slotted_page_slot_manager spm_checker u_spm_checker (.*);

// File: tb/slotted_page_slot_manager_test.sv
`timescale 1ns / 1ps

module slotted_page_slot_manager_test;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 32;
  localparam int SLOT_BYTES   = 4;
  localparam int MAX_SLOTS    = 1024;

  localparam int unsigned NIL_LINK  = MAX_SLOTS;
  localparam int unsigned MAX_TUPLE = PAGE_BYTES - HEADER_BYTES - SLOT_BYTES;
  localparam int unsigned MAX_GAP   = 12;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned LONG_HOLD  = 200;

  // kinds with no meaning, the block must answer them and change nothing
  localparam logic [spm_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [spm_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic [spm_pkg::STATUS_W-1:0] status;
    logic [spm_pkg::SLOT_W-1:0]   slot;
    logic [spm_pkg::OFF_W-1:0]    offset;
    logic [spm_pkg::TLEN_W-1:0]   length;
    logic [spm_pkg::CNT_W-1:0]    alive;
    logic [spm_pkg::CNT_W-1:0]    deleted;
    logic [spm_pkg::FREE_W-1:0]   free;
  } page_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // kind, slot_index, tuple_length from the lowest bit up
  logic [spm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // status, result_slot, data_offset, data_length, live_tuples, dead_slots, free_bytes
  logic [spm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  slotted_page_slot_manager #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .SLOT_BYTES  (SLOT_BYTES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the slot directory and page counters
  int unsigned dir_offset [MAX_SLOTS];
  int unsigned dir_length [MAX_SLOTS];
  bit          dir_deleted [MAX_SLOTS];
  int unsigned dir_used       = 0;
  int unsigned live_count     = 0;
  int unsigned dead_count     = 0;
  int unsigned tuple_floor    = PAGE_BYTES;
  int unsigned free_top       = NIL_LINK;

  page_result_t pending_results [$];

  bit          sender_idles   = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned output_hold    = 0;

  int unsigned error_total   = 0;
  int unsigned request_total = 0;
  int unsigned result_total  = 0;
  int unsigned reuse_tally   = 0;
  int unsigned status_tally [8];

  function automatic int unsigned bytes_free();
    int unsigned area_end;
    area_end = HEADER_BYTES + dir_used * SLOT_BYTES;
    return (tuple_floor <= area_end) ? 0 : tuple_floor - area_end;
  endfunction

  function automatic bit length_invalid(int unsigned len);
    return len == 0 || len > MAX_TUPLE;
  endfunction

  // next state and result of one request
  function automatic page_result_t apply_request(int unsigned kind, int unsigned sidx,
                                                 int unsigned len);
    page_result_t r;
    int unsigned  reuse;
    int unsigned  nxt;
    int unsigned  need;
    int unsigned  s;
    bit           fresh;
    r.status = spm_pkg::STS_OK;
    r.slot   = spm_pkg::SLOT_W'(sidx);
    r.offset = '0;
    r.length = '0;
    case (kind)
      spm_pkg::KIND_INIT: begin
        // slot entries survive, only the counters start over
        dir_used       = 0;
        live_count     = 0;
        dead_count     = 0;
        tuple_floor    = PAGE_BYTES;
        free_top       = NIL_LINK;
      end
      spm_pkg::KIND_INSERT: begin
        r.slot = '0;
        if (length_invalid(len)) begin
          r.status = spm_pkg::STS_BAD_SIZE;
        end else begin
          reuse = NIL_LINK;
          nxt   = NIL_LINK;
          if (free_top != NIL_LINK) begin
            reuse = free_top;
            if (reuse >= dir_used || !dir_deleted[reuse]) begin
              r.status = spm_pkg::STS_CORRUPT;
            end else begin
              nxt = dir_offset[reuse];
              if (nxt != NIL_LINK && nxt >= dir_used) r.status = spm_pkg::STS_CORRUPT;
            end
          end
          if (r.status == spm_pkg::STS_OK) begin
            fresh = (reuse == NIL_LINK);
            need  = len + (fresh ? SLOT_BYTES : 0);
            if (bytes_free() < need || (fresh && dir_used >= MAX_SLOTS)) begin
              r.status = spm_pkg::STS_NO_SPACE;
            end else if (!fresh && dead_count == 0) begin
              r.status = spm_pkg::STS_CORRUPT;
            end else begin
              s = fresh ? dir_used : reuse;
              if (!fresh) begin
                free_top = nxt;
                dead_count--;
                reuse_tally++;
              end
              tuple_floor -= len;
              dir_offset[s]  = tuple_floor;
              dir_length[s]  = len;
              dir_deleted[s] = 1'b0;
              if (fresh) dir_used++;
              live_count++;
              r.slot   = spm_pkg::SLOT_W'(s);
              r.offset = spm_pkg::OFF_W'(tuple_floor);
              r.length = spm_pkg::TLEN_W'(len);
            end
          end
        end
      end
      spm_pkg::KIND_UPDATE: begin
        if (sidx >= dir_used) begin
          r.status = spm_pkg::STS_RANGE;
        end else if (dir_deleted[sidx]) begin
          r.status = spm_pkg::STS_DELETED;
        end else if (length_invalid(len)) begin
          r.status = spm_pkg::STS_BAD_SIZE;
        end else if (len <= dir_length[sidx]) begin
          // shrinking keeps the tuple in place
          dir_length[sidx] = len;
          r.offset = spm_pkg::OFF_W'(dir_offset[sidx]);
          r.length = spm_pkg::TLEN_W'(len);
        end else if (bytes_free() < len) begin
          r.status = spm_pkg::STS_NO_SPACE;
        end else begin
          tuple_floor -= len;
          dir_offset[sidx] = tuple_floor;
          dir_length[sidx] = len;
          r.offset = spm_pkg::OFF_W'(tuple_floor);
          r.length = spm_pkg::TLEN_W'(len);
        end
      end
      spm_pkg::KIND_DELETE: begin
        if (sidx >= dir_used) begin
          r.status = spm_pkg::STS_RANGE;
        end else if (dir_deleted[sidx]) begin
          r.status = spm_pkg::STS_DELETED;
        end else begin
          // the offset entry becomes the free-list link
          dir_offset[sidx]  = free_top;
          dir_deleted[sidx] = 1'b1;
          free_top          = sidx;
          if (live_count > 0) live_count--;
          dead_count++;
        end
      end
      spm_pkg::KIND_GET: begin
        if (sidx >= dir_used) begin
          r.status = spm_pkg::STS_RANGE;
        end else if (dir_deleted[sidx]) begin
          r.status = spm_pkg::STS_DELETED;
        end else if (dir_length[sidx] == 0 ||
                     dir_offset[sidx] + dir_length[sidx] > PAGE_BYTES) begin
          r.status = spm_pkg::STS_CONTENT;
        end else begin
          r.offset = spm_pkg::OFF_W'(dir_offset[sidx]);
          r.length = spm_pkg::TLEN_W'(dir_length[sidx]);
        end
      end
      default: ;
    endcase
    r.alive   = spm_pkg::CNT_W'(live_count);
    r.deleted = spm_pkg::CNT_W'(dead_count);
    r.free    = spm_pkg::FREE_W'(bytes_free());
    return r;
  endfunction

  // mostly slots in use, now and then anywhere in the index range
  function automatic int unsigned pick_slot();
    if (dir_used > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, dir_used - 1);
    return $urandom_range(0, MAX_SLOTS - 1);
  endfunction

  // mostly small tuples, some large, some illegal, some an exact fit
  function automatic int unsigned pick_length();
    int unsigned r;
    int unsigned room;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 48);
    if (r < 85) return $urandom_range(49, 600);
    if (r < 91) return $urandom_range(601, MAX_TUPLE);
    if (r < 94) return 0;
    if (r < 97) return $urandom_range(MAX_TUPLE + 1, (1 << spm_pkg::TLEN_W) - 1);
    room = bytes_free();
    if (room > SLOT_BYTES && $urandom_range(0, 1)) return room - SLOT_BYTES;
    return room;
  endfunction

  task automatic report_mismatch(string msg);
    error_total++;
    if (error_total <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", result_total, name, got, want));
  endtask

  // offers one request, waits for the handshake, then records what it should produce
  task automatic send_request(int unsigned kind, int unsigned slot, int unsigned len);
    int unsigned                  gap;
    logic [spm_pkg::KIND_W-1:0]   k;
    logic [spm_pkg::SLOT_W-1:0]   s;
    logic [spm_pkg::TLEN_W-1:0]   l;
    page_result_t                 want;
    k = spm_pkg::KIND_W'(kind);
    s = spm_pkg::SLOT_W'(slot);
    l = spm_pkg::TLEN_W'(len);
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    // valid stays high between back-to-back requests
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= spm_pkg::IN_TDATA_W'({l, s, k});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    want = apply_request(k, s, l);
    pending_results.push_back(want);
    status_tally[want.status]++;
    request_total++;
  endtask

  task automatic check_result(logic [spm_pkg::OUT_TDATA_W-1:0] word);
    page_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with no request pending: %h", word));
    end else begin
      want = pending_results.pop_front();
      compare_field("status",        word[2:0],   want.status);
      compare_field("result_slot",   word[12:3],  want.slot);
      compare_field("data_offset",   word[25:13], want.offset);
      compare_field("data_length",   word[38:26], want.length);
      compare_field("live_tuples",   word[49:39], want.alive);
      compare_field("dead_slots",    word[60:50], want.deleted);
      compare_field("free_bytes",    word[73:61], want.free);
    end
    result_total++;
  endtask

  // result side: random stalls, plus one long hold when asked
  initial begin : result_side
    int unsigned gap;
    do @(posedge clk); while (rst);
    forever begin
      if (output_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (output_hold) @(posedge clk);
        output_hold = 0;
      end
      gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      check_result(m_axis_tdata);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
    $display("[slotted_page_slot_manager] ERROR");
    $finish;
  end

  // reset state, then the length limits
  task automatic test_reset_and_size_limits();
    send_request(spm_pkg::KIND_GET, 0, 0);
    send_request(spm_pkg::KIND_INIT, MAX_SLOTS - 1, (1 << spm_pkg::TLEN_W) - 1);
    send_request(spm_pkg::KIND_INSERT, 0, 0);
    send_request(spm_pkg::KIND_INSERT, 0, (1 << spm_pkg::TLEN_W) - 1);
    send_request(spm_pkg::KIND_INSERT, 0, MAX_TUPLE + 1);
  endtask

  // one maximum tuple takes the whole page
  task automatic test_page_full();
    send_request(spm_pkg::KIND_INSERT, 0, MAX_TUPLE);
    send_request(spm_pkg::KIND_INSERT, 0, 1);
    send_request(spm_pkg::KIND_GET, 0, 0);
    send_request(spm_pkg::KIND_UPDATE, 0, 10);
    send_request(spm_pkg::KIND_UPDATE, 0, 11);
    send_request(spm_pkg::KIND_UPDATE, 1, 5);
  endtask

  // deleted slots are refused, then handed out again last in first out
  task automatic test_delete_and_reuse();
    send_request(spm_pkg::KIND_INIT, 0, 0);
    send_request(spm_pkg::KIND_INSERT, 0, 100);
    send_request(spm_pkg::KIND_INSERT, 0, 200);
    send_request(spm_pkg::KIND_DELETE, 0, 0);
    send_request(spm_pkg::KIND_DELETE, 0, 0);
    send_request(spm_pkg::KIND_GET, 0, 0);
    send_request(spm_pkg::KIND_UPDATE, 0, 5);
    send_request(spm_pkg::KIND_DELETE, 1, 0);
    send_request(spm_pkg::KIND_INSERT, 0, 5);
    send_request(spm_pkg::KIND_INSERT, 0, 6);
    send_request(spm_pkg::KIND_INSERT, 0, 7);
    send_request(spm_pkg::KIND_UPDATE, 2, 50);
  endtask

  task automatic test_unknown_kinds();
    send_request(KIND_SPARE_HI, MAX_SLOTS - 1, (1 << spm_pkg::TLEN_W) - 1);
    send_request(KIND_SPARE_LO, 0, 0);
  endtask

  // receiver stops for a long while so the block backs up onto its input
  task automatic test_output_stall();
    sender_idles = 1'b0;
    output_hold  = LONG_HOLD;
    repeat (16) send_request($urandom_range(0, 1) ? spm_pkg::KIND_INSERT : spm_pkg::KIND_GET,
                             pick_slot(), pick_length());
    sender_idles = 1'b1;
  endtask

  // sessions that start with init and fill, churn and drain the page
  task automatic test_random_traffic(int unsigned target);
    int unsigned counted;
    int unsigned session_left;
    int unsigned pick;
    int unsigned kind;
    int unsigned slot;
    int unsigned len;
    bit          noisy;
    counted = 0;
    while (counted < target) begin
      session_left   = $urandom_range(40, 360);
      noisy          = ($urandom_range(0, 9) == 0);
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      send_request(spm_pkg::KIND_INIT, $urandom, $urandom);
      counted++;
      while (session_left > 0 && counted < target) begin
        pick = $urandom_range(0, 99);
        slot = pick_slot();
        len  = pick_length();
        if (noisy || pick >= 95) begin
          kind = $urandom_range(spm_pkg::KIND_INIT, KIND_SPARE_HI);
          slot = $urandom;
          len  = $urandom;
        end else if (pick < 40) begin
          kind = spm_pkg::KIND_INSERT;
        end else if (pick < 55) begin
          kind = spm_pkg::KIND_UPDATE;
        end else if (pick < 70) begin
          kind = spm_pkg::KIND_DELETE;
        end else begin
          kind = spm_pkg::KIND_GET;
        end
        send_request(kind, slot, len);
        if (spm_pkg::KIND_W'(kind) <= spm_pkg::KIND_GET) counted++;
        session_left--;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_and_size_limits();
    test_page_full();
    test_delete_and_reuse();
    test_unknown_kinds();
    test_output_stall();
    test_random_traffic(1650);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // room for any stray result to show up
    repeat (4 + 2 * MAX_GAP) @(posedge clk);
    $display("%0d requests and %0d results checked, %0d inserts on a reused slot",
             request_total, result_total, reuse_tally);
    $display("status mix: ok %0d, bad size %0d, no space %0d, out of range %0d, deleted %0d",
             status_tally[spm_pkg::STS_OK], status_tally[spm_pkg::STS_BAD_SIZE],
             status_tally[spm_pkg::STS_NO_SPACE], status_tally[spm_pkg::STS_RANGE],
             status_tally[spm_pkg::STS_DELETED]);
    if (error_total == 0) begin
      $display("[slotted_page_slot_manager] OK");
    end else begin
      $display("[slotted_page_slot_manager] ERROR");
    end
    $finish;
  end

endmodule
